FILE: rtl/core/thq_pkg.sv
// Shared types, constants and command/status bundles for the timeout heap queue.
`default_nettype none
package thq_pkg;

    localparam int HEAP_ENTRIES_DEF = 64;
    localparam int TIME_BITS_DEF    = 48;

    localparam int NUM_IDS    = 64;
    localparam int ID_W       = 6;
    localparam int TMO_W      = 32;
    localparam int NOW_W      = 48;
    localparam int ST_W       = 3;
    localparam int RESULT_CAP = 64;
    localparam int N_W        = 7;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_NOP    = 2'd3
    } t_req;

    typedef enum logic [ST_W-1:0] {
        ST_ACK     = 3'd0,
        ST_EXPIRED = 3'd1,
        ST_NONE    = 3'd2,
        ST_FULL    = 3'd3,
        ST_QUEUED  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        RD_CUR   = 3'd0,
        RD_LAST  = 3'd1,
        RD_LEFT  = 3'd2,
        RD_RIGHT = 3'd3,
        RD_ROOT  = 3'd4
    } t_rd_src;

    typedef struct packed {
        logic    capture;
        logic    set_pend;
        t_status pend_code;
        logic    pend_zero_id;
        logic    ins_start;
        logic    id_rd;
        logic    unqueue;
        logic    tick_start;
        logic    rm;
        logic    rm_root;
        logic    take_rd;
        logic    rd_en;
        t_rd_src rd_src;
        logic    walk_step;
        logic    wr_item;
        logic    save_left;
        logic    swap;
        logic    pop;
        logic    emit;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic queued;
        logic full;
        logic h_ok;
        logic del_last;
        logic root_last;
        logic sh_zero;
        logic no_left;
        logic swap_ok;
        logic tick_stop;
        logic root_due;
        logic pend_v;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

FILE: rtl/core/thq_ctrl.sv
// Sequencer for the timeout heap queue: decodes requests and steps the heap walks.
`default_nettype none
module thq_ctrl import thq_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_idle
);

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_DEC  = 12'b000000000010,
        S_DCHK = 12'b000000000100,
        S_LGET = 12'b000000001000,
        S_WRD  = 12'b000000010000,
        S_WCMP = 12'b000000100000,
        S_SL   = 12'b000001000000,
        S_SR   = 12'b000010000000,
        S_SC   = 12'b000100000000,
        S_TRD  = 12'b001000000000,
        S_TCMP = 12'b010000000000,
        S_EMIT = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_is_ins, n_is_ins;
    logic   r_is_tick, n_is_tick;

    always_comb begin
        n_state   = r_state;
        n_is_ins  = r_is_ins;
        n_is_tick = r_is_tick;
        o_cmd     = '0;
        o_cmd.pend_code = ST_ACK;
        o_cmd.rd_src    = RD_CUR;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_is_ins  = 1'b0;
                n_is_tick = 1'b0;
                unique case (i_stat.req)
                    REQ_INSERT: begin
                        o_cmd.set_pend = 1'b1;
                        if (i_stat.queued) begin
                            o_cmd.pend_code = ST_QUEUED;
                            n_state = S_EMIT;
                        end else if (i_stat.full) begin
                            o_cmd.pend_code = ST_FULL;
                            n_state = S_EMIT;
                        end else begin
                            o_cmd.ins_start = 1'b1;
                            n_is_ins = 1'b1;
                            n_state  = S_WRD;
                        end
                    end
                    REQ_DELETE: begin
                        o_cmd.set_pend = 1'b1;
                        if (i_stat.queued) begin
                            o_cmd.unqueue = 1'b1;
                            o_cmd.id_rd   = 1'b1;
                            n_state = S_DCHK;
                        end else begin
                            n_state = S_EMIT;
                        end
                    end
                    REQ_TICK: begin
                        o_cmd.tick_start = 1'b1;
                        n_is_tick = 1'b1;
                        n_state   = S_TRD;
                    end
                    default: begin
                        o_cmd.set_pend     = 1'b1;
                        o_cmd.pend_zero_id = 1'b1;
                        n_state = S_EMIT;
                    end
                endcase
            end
            S_DCHK: begin
                if (i_stat.h_ok) begin
                    o_cmd.rm     = 1'b1;
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = RD_LAST;
                    n_state = i_stat.del_last ? S_EMIT : S_LGET;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_LGET: begin
                o_cmd.take_rd = 1'b1;
                n_state = S_WRD;
            end
            S_WRD: begin
                if (i_stat.sh_zero) begin
                    o_cmd.wr_item = 1'b1;
                    n_state = r_is_ins ? S_EMIT : S_SL;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = RD_CUR;
                    n_state = S_WCMP;
                end
            end
            S_WCMP: begin
                o_cmd.walk_step = 1'b1;
                n_state = S_WRD;
            end
            S_SL: begin
                if (i_stat.no_left) begin
                    o_cmd.wr_item = 1'b1;
                    n_state = r_is_tick ? S_TRD : S_EMIT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = RD_LEFT;
                    n_state = S_SR;
                end
            end
            S_SR: begin
                o_cmd.save_left = 1'b1;
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_src    = RD_RIGHT;
                n_state = S_SC;
            end
            S_SC: begin
                if (i_stat.swap_ok) begin
                    o_cmd.swap = 1'b1;
                    n_state = S_SL;
                end else begin
                    o_cmd.wr_item = 1'b1;
                    n_state = r_is_tick ? S_TRD : S_EMIT;
                end
            end
            S_TRD: begin
                if (i_stat.tick_stop) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_src = RD_ROOT;
                    n_state = S_TCMP;
                end
            end
            S_TCMP: begin
                if (!i_stat.root_due) begin
                    n_state = S_EMIT;
                end else if (!i_stat.pend_v || i_stat.out_free) begin
                    o_cmd.pop     = 1'b1;
                    o_cmd.rm      = 1'b1;
                    o_cmd.rm_root = 1'b1;
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_src  = RD_LAST;
                    n_state = i_stat.root_last ? S_TRD : S_LGET;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_is_ins  <= 1'b0;
            r_is_tick <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_is_ins  <= n_is_ins;
            r_is_tick <= n_is_tick;
        end
    end

    assign o_idle = (r_state == S_IDLE);

endmodule
`default_nettype wire

FILE: rtl/core/thq_datapath.sv
// Heap storage, id map, time arithmetic and result register of the timeout heap queue.
`default_nettype none
module thq_datapath import thq_pkg::*; #(
    parameter int HEAP_ENTRIES = HEAP_ENTRIES_DEF,
    parameter int TIME_BITS    = TIME_BITS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire  [1:0]        i_req_type,
    input  wire  [ID_W-1:0]   i_thread_id,
    input  wire  [TMO_W-1:0]  i_timeout,
    input  wire  [NOW_W-1:0]  i_now_time,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    output logic              o_valid,
    input  wire               i_ready,
    output logic [ST_W-1:0]   o_status,
    output logic [ID_W-1:0]   o_out_id,
    output logic              o_is_last
);

    localparam int SW   = $clog2(HEAP_ENTRIES + 1);
    localparam int SHW  = $clog2(SW);
    localparam int SUMW = ((TIME_BITS > TMO_W) ? TIME_BITS : TMO_W) + 1;
    localparam int NWW  = (TIME_BITS > NOW_W) ? TIME_BITS : NOW_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    function automatic logic [SHW-1:0] top_bit(input logic [SW-1:0] x);
        logic [SHW-1:0] t;
        t = '0;
        for (int i = 0; i < SW; i++) begin
            if (x[i]) t = SHW'(i);
        end
        return t;
    endfunction

    // request capture
    t_req             r_req;
    logic [ID_W-1:0]  r_id;
    logic [TMO_W-1:0] r_tmo;
    logic [NOW_W-1:0] r_now;

    // control state
    logic [SW-1:0]        r_count;
    logic [TIME_BITS-1:0] r_clock;
    logic [NUM_IDS-1:0]   r_queued;
    logic [N_W-1:0]       r_n;
    logic                 r_pv;
    logic                 r_ovalid;

    // storage
    logic [ID_W-1:0]      r_slot_id  [0:HEAP_ENTRIES];
    logic [TIME_BITS-1:0] r_slot_due [0:HEAP_ENTRIES];
    logic [SW-1:0]        r_id_slot  [0:NUM_IDS-1];

    // working payload
    logic [ID_W-1:0]      r_rd_id, r_l_id, r_item_id;
    logic [TIME_BITS-1:0] r_rd_due, r_l_due, r_item_due;
    logic                 r_hasr;
    logic [SW-1:0]        r_ids_rd, r_target, r_cur;
    logic [SHW-1:0]       r_sh;
    t_status              r_pstat;
    logic [ID_W-1:0]      r_pid;
    logic [ST_W-1:0]      r_ostat;
    logic [ID_W-1:0]      r_oid;
    logic                 r_olast;

    logic [SW-1:0]        cnt_inc, h_sel, left_a, right_a, rd_addr;
    logic [SUMW-1:0]      sum;
    logic [TIME_BITS-1:0] due_ins, now_t, y_due, wr_due;
    logic [NWW-1:0]       now_w;
    logic [ID_W-1:0]      y_id, wr_id;
    logic                 y_right, swap_ok, walk_less, wr_en, out_free, has_right_c;

    assign cnt_inc = r_count + 1'b1;
    assign h_sel   = i_cmd.rm_root ? SW'(1) : r_ids_rd;
    assign left_a  = {r_cur[SW-2:0], 1'b0};
    assign right_a = {r_cur[SW-2:0], 1'b1};
    assign has_right_c = {r_cur, 1'b1} <= {1'b0, r_count};

    // saturating due time
    assign sum     = SUMW'(r_clock) + SUMW'(r_tmo);
    assign due_ins = (sum > SUMW'(TIME_MAX)) ? TIME_MAX : sum[TIME_BITS-1:0];
    assign now_w   = NWW'(r_now);
    assign now_t   = now_w[TIME_BITS-1:0];

    // sift-down child pick: right unless left strictly smaller
    assign y_right   = r_hasr && !(r_l_due < r_rd_due);
    assign y_id      = y_right ? r_rd_id  : r_l_id;
    assign y_due     = y_right ? r_rd_due : r_l_due;
    assign swap_ok   = r_item_due > y_due;
    assign walk_less = r_item_due < r_rd_due;

    assign wr_en  = i_cmd.wr_item || i_cmd.swap || (i_cmd.walk_step && walk_less);
    assign wr_id  = i_cmd.swap ? y_id  : r_item_id;
    assign wr_due = i_cmd.swap ? y_due : r_item_due;
    assign out_free = !r_ovalid || i_ready;

    always_comb begin
        case (i_cmd.rd_src)
            RD_CUR:   rd_addr = r_cur;
            RD_LAST:  rd_addr = r_count;
            RD_LEFT:  rd_addr = left_a;
            RD_RIGHT: rd_addr = right_a;
            RD_ROOT:  rd_addr = SW'(1);
            default:  rd_addr = r_cur;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot_id[r_cur]  <= wr_id;
            r_slot_due[r_cur] <= wr_due;
            r_id_slot[wr_id]  <= r_cur;
        end
        if (i_cmd.rd_en) begin
            r_rd_id  <= r_slot_id[rd_addr];
            r_rd_due <= r_slot_due[rd_addr];
        end
        if (i_cmd.id_rd) r_ids_rd <= r_id_slot[r_id];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= t_req'(i_req_type);
            r_id  <= i_thread_id;
            r_tmo <= i_timeout;
            r_now <= i_now_time;
        end
        if (i_cmd.ins_start) begin
            r_item_id  <= r_id;
            r_item_due <= due_ins;
            r_target   <= cnt_inc;
            r_cur      <= SW'(1);
            r_sh       <= top_bit(cnt_inc);
        end
        if (i_cmd.rm) begin
            r_target <= h_sel;
            r_cur    <= SW'(1);
            r_sh     <= top_bit(h_sel);
        end
        if (i_cmd.take_rd) begin
            r_item_id  <= r_rd_id;
            r_item_due <= r_rd_due;
        end
        if (i_cmd.walk_step) begin
            if (walk_less) begin
                r_item_id  <= r_rd_id;
                r_item_due <= r_rd_due;
            end
            r_cur <= SW'(r_target >> (r_sh - 1'b1));
            r_sh  <= r_sh - 1'b1;
        end
        if (i_cmd.save_left) begin
            r_l_id  <= r_rd_id;
            r_l_due <= r_rd_due;
            r_hasr  <= has_right_c;
        end
        if (i_cmd.swap) r_cur <= y_right ? right_a : left_a;
        if (i_cmd.set_pend) begin
            r_pstat <= i_cmd.pend_code;
            r_pid   <= i_cmd.pend_zero_id ? '0 : r_id;
        end
        if (i_cmd.pop) begin
            r_pstat <= ST_EXPIRED;
            r_pid   <= r_rd_id;
            // only a held expiry moves out; a waiting result stays put
            if (r_pv) begin
                r_ostat <= r_pstat;
                r_oid   <= r_pid;
                r_olast <= 1'b0;
            end
        end
        if (i_cmd.emit) begin
            r_ostat <= r_pv ? r_pstat : ST_NONE;
            r_oid   <= r_pv ? r_pid : '0;
            r_olast <= 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_clock  <= '0;
            r_queued <= '0;
            r_n      <= '0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.ins_start) begin
                r_count        <= cnt_inc;
                r_queued[r_id] <= 1'b1;
            end
            if (i_cmd.rm)      r_count <= r_count - 1'b1;
            if (i_cmd.unqueue) r_queued[r_id] <= 1'b0;
            if (i_cmd.set_pend) r_pv <= 1'b1;
            if (i_cmd.tick_start) begin
                r_clock <= now_t;
                r_n     <= '0;
                r_pv    <= 1'b0;
            end
            if (i_cmd.pop) begin
                r_queued[r_rd_id] <= 1'b0;
                r_n  <= r_n + 1'b1;
                r_pv <= 1'b1;
            end
            if ((i_cmd.pop && r_pv) || i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.req       = r_req;
        o_stat.queued    = r_queued[r_id];
        o_stat.full      = r_count >= SW'(HEAP_ENTRIES);
        o_stat.h_ok      = (r_ids_rd != '0) && (r_ids_rd <= r_count);
        o_stat.del_last  = r_count == r_ids_rd;
        o_stat.root_last = r_count == SW'(1);
        o_stat.sh_zero   = r_sh == '0;
        o_stat.no_left   = {r_cur, 1'b0} > {1'b0, r_count};
        o_stat.swap_ok   = swap_ok;
        o_stat.tick_stop = (r_n == N_W'(RESULT_CAP)) || (r_count == '0);
        o_stat.root_due  = r_rd_due <= r_clock;
        o_stat.pend_v    = r_pv;
        o_stat.out_free  = out_free;
    end

    assign o_valid   = r_ovalid;
    assign o_status  = r_ostat;
    assign o_out_id  = r_oid;
    assign o_is_last = r_olast;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SW'(HEAP_ENTRIES)) else $error("heap count above capacity");
    a_pop_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= N_W'(RESULT_CAP)) else $error("tick popped past the cap");
    a_pop_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (!r_pv || out_free)) else $error("pop would drop a pending result");
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_ovalid && r_olast)) else $error("final result not presented");

endmodule
`default_nettype wire

FILE: rtl/core/timeout_heap_queue.sv
// Top level of the timeout heap queue: request port, sequencer and datapath.
`default_nettype none
// Sleep queue of thread ids held as a binary min-heap on due time, in one
// memory with one read port (registered) and one write port. A request is
// taken only when the block is idle; o_ready is high then. Insert stores
// due = last tick time + timeout (saturating) and walks the root-to-last path
// level by level, reading and then comparing at each level. Delete adds an
// id lookup, a walk to the hole and a sift-down that reads the left child,
// then the right, then compares; walk and sift share one root-to-leaf path.
// A tick removes due ids from the root one at a time, much as a delete does,
// and each expiry is one result with o_is_last low except the last; a tick
// with nothing due gives one "none expired" result. One result register
// decouples the output side; the block stalls in place while a result waits
// and another is ready. No clearing pass after reset.
module timeout_heap_queue import thq_pkg::*; #(
    parameter int HEAP_ENTRIES = HEAP_ENTRIES_DEF,
    parameter int TIME_BITS    = TIME_BITS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire  [1:0]       i_req_type,
    input  wire  [ID_W-1:0]  i_thread_id,
    input  wire  [TMO_W-1:0] i_timeout,
    input  wire  [NOW_W-1:0] i_now_time,
    output logic             o_valid,
    input  wire              i_ready,
    output logic [ST_W-1:0]  o_status,
    output logic [ID_W-1:0]  o_out_id,
    output logic             o_is_last
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer: one request at a time
    thq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_idle  (o_ready)
    );

    // heap storage and result register
    thq_datapath #(
        .HEAP_ENTRIES (HEAP_ENTRIES),
        .TIME_BITS    (TIME_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_type  (i_req_type),
        .i_thread_id (i_thread_id),
        .i_timeout   (i_timeout),
        .i_now_time  (i_now_time),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_out_id    (o_out_id),
        .o_is_last   (o_is_last)
    );

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the timeout heap queue: heap predictor, driver and monitor.
`timescale 1ns / 100ps
module tb;
    import thq_pkg::*;

    // One request as offered on the input port, plus driver controls.
    typedef struct {
        t_req         req;
        logic [5:0]   id;
        logic [31:0]  tmo;
        logic [47:0]  now;
        int           phase;   // idle profile to use from this request on
        bit           drain;   // wait until all results are back first
        bit           hold;    // start the long receiver hold-off
    } req_t;

    typedef struct {
        t_status     st;
        logic [5:0]  id;
        logic        last;
    } result_t;

    localparam logic [47:0] DUE_MAX = 48'hFFFF_FFFF_FFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_ready = 1'b0;
    logic [1:0]  i_req_type = 2'd0;
    logic [5:0]  i_thread_id = 6'd0;
    logic [31:0] i_timeout = 32'd0;
    logic [47:0] i_now_time = 48'd0;
    wire         o_ready;
    wire         o_valid;
    wire [2:0]   o_status;
    wire [5:0]   o_out_id;
    wire         o_is_last;

    timeout_heap_queue u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_type  (i_req_type),
        .i_thread_id (i_thread_id),
        .i_timeout   (i_timeout),
        .i_now_time  (i_now_time),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_out_id    (o_out_id),
        .o_is_last   (o_is_last)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Heap predictor: slots 1..heap_cnt, children of s are 2s and 2s+1.
    // ------------------------------------------------------------------
    logic [5:0]  heap_id  [1:64];
    logic [47:0] heap_due [1:64];
    int          slot_of  [64];
    bit          sleeping [64];
    int          heap_cnt = 0;
    logic [47:0] last_tick = '0;

    req_t    pend_q[$];
    result_t due_results[$];
    req_t    cur_req;
    int      errors = 0;

    function automatic void set_slot(int s, logic [5:0] id, logic [47:0] due);
        heap_id[s]  = id;
        heap_due[s] = due;
        slot_of[id] = s;
    endfunction

    // Root-to-target walk; a strictly later entry on the path is pushed down.
    function automatic void place_on_path(int target, logic [5:0] id, logic [47:0] due);
        int top;
        int cur;
        logic [5:0]  tid;
        logic [47:0] tdue;
        top = 0;
        cur = 1;
        while ((target >> (top + 1)) != 0) top++;
        for (int b = top - 1; b >= 0; b--) begin
            if (due < heap_due[cur]) begin
                tid  = heap_id[cur];
                tdue = heap_due[cur];
                set_slot(cur, id, due);
                id  = tid;
                due = tdue;
            end
            cur = (cur << 1) | ((target >> b) & 1);
        end
        set_slot(target, id, due);
    endfunction

    function automatic void sink(int cur);
        int l;
        int y;
        logic [5:0]  cid;
        logic [47:0] cdue;
        forever begin
            l = cur << 1;
            if (l > heap_cnt) break;
            y = l;
            // ties go to the right child
            if (l + 1 <= heap_cnt && !(heap_due[l] < heap_due[l + 1])) y = l + 1;
            if (heap_due[cur] > heap_due[y]) begin
                cid  = heap_id[cur];
                cdue = heap_due[cur];
                set_slot(cur, heap_id[y], heap_due[y]);
                set_slot(y, cid, cdue);
                cur = y;
            end else begin
                break;
            end
        end
    endfunction

    function automatic void unlink(logic [5:0] id);
        int h;
        int last;
        h = slot_of[id];
        last = heap_cnt;
        sleeping[id] = 0;
        if (h == 0 || h > heap_cnt) return;
        heap_cnt--;
        if (last != h) begin
            place_on_path(h, heap_id[last], heap_due[last]);
            sink(h);
        end
    endfunction

    function automatic void add_result(t_status st, logic [5:0] id, logic last);
        result_t r;
        r.st = st;
        r.id = id;
        r.last = last;
        due_results.push_back(r);
    endfunction

    // Works out the results of one accepted request and updates the heap.
    function automatic void predict_request(req_t r);
        logic [48:0] sum;
        logic [5:0]  top_id;
        int n;
        n = 0;
        case (r.req)
            REQ_INSERT: begin
                if (sleeping[r.id]) begin
                    add_result(ST_QUEUED, r.id, 1'b1);
                end else if (heap_cnt >= 64) begin
                    add_result(ST_FULL, r.id, 1'b1);
                end else begin
                    sum = {1'b0, last_tick} + {17'd0, r.tmo};
                    heap_cnt++;
                    sleeping[r.id] = 1;
                    place_on_path(heap_cnt, r.id, sum[48] ? DUE_MAX : sum[47:0]);
                    add_result(ST_ACK, r.id, 1'b1);
                end
            end
            REQ_DELETE: begin
                if (sleeping[r.id]) unlink(r.id);
                add_result(ST_ACK, r.id, 1'b1);
            end
            REQ_TICK: begin
                last_tick = r.now;
                while (n < RESULT_CAP && heap_cnt > 0 && heap_due[1] <= r.now) begin
                    top_id = heap_id[1];
                    unlink(top_id);
                    add_result(ST_EXPIRED, top_id, 1'b0);
                    n++;
                end
                if (n == 0) add_result(ST_NONE, 6'd0, 1'b1);
                else due_results[$].last = 1'b1;
            end
            default: add_result(ST_ACK, 6'd0, 1'b1);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus build-up
    // ------------------------------------------------------------------
    logic [47:0] sim_now = '0;   // tick time used by the random part

    function automatic void queue_req(t_req rq, logic [5:0] id, logic [31:0] tmo,
                                      logic [47:0] now, int phase);
        req_t r;
        r.req = rq;
        r.id = id;
        r.tmo = tmo;
        r.now = now;
        r.phase = phase;
        r.drain = 0;
        r.hold = 0;
        pend_q.push_back(r);
    endfunction

    function automatic void queue_random(int phase);
        int pick;
        logic [31:0] tmo;
        pick = $urandom_range(99);
        if (pick < 45) begin
            tmo = ($urandom_range(9) == 0) ? $urandom : $urandom_range(2000);
            queue_req(REQ_INSERT, 6'($urandom_range(63)), tmo,
                      48'({$urandom, $urandom}), phase);
        end else if (pick < 65) begin
            queue_req(REQ_DELETE, 6'($urandom_range(63)), $urandom,
                      48'({$urandom, $urandom}), phase);
        end else if (pick < 95) begin
            sim_now = sim_now + 48'($urandom_range(800));
            queue_req(REQ_TICK, 6'($urandom), $urandom, sim_now, phase);
        end else if (pick < 97) begin
            // time jump anywhere in the range; later inserts may saturate
            sim_now = 48'({$urandom, $urandom});
            queue_req(REQ_TICK, 6'($urandom), $urandom, sim_now, phase);
        end else begin
            queue_req(REQ_NOP, 6'($urandom), $urandom, 48'({$urandom, $urandom}), phase);
        end
    endfunction

    initial begin
        // directed: extremes, duplicates, ticks with and without expiries
        queue_req(REQ_INSERT, 6'd0, 32'd0, '0, 0);
        queue_req(REQ_INSERT, 6'd63, 32'hFFFF_FFFF, '0, 0);
        queue_req(REQ_INSERT, 6'd0, 32'd5, '0, 0);           // already queued
        queue_req(REQ_INSERT, 6'd21, 32'd7, '0, 0);
        queue_req(REQ_INSERT, 6'd42, 32'd7, '0, 0);          // equal due times
        queue_req(REQ_DELETE, 6'd5, 32'd0, '0, 0);           // not queued
        queue_req(REQ_NOP, 6'd33, 32'h5555_5555, 48'hAAAA_AAAA_AAAA, 0);
        queue_req(REQ_TICK, 6'd0, 32'd0, 48'd0, 0);          // pops id 0
        queue_req(REQ_TICK, 6'd0, 32'd0, 48'd0, 0);          // nothing due
        queue_req(REQ_DELETE, 6'd21, 32'd0, '0, 0);          // queued, not last
        queue_req(REQ_TICK, 6'd0, 32'd0, DUE_MAX, 0);        // pops the rest
        queue_req(REQ_INSERT, 6'd9, 32'hFFFF_FFFF, '0, 0);   // saturates
        queue_req(REQ_INSERT, 6'd10, 32'd1, '0, 0);          // saturates
        queue_req(REQ_TICK, 6'd0, 32'd0, DUE_MAX, 0);
        queue_req(REQ_TICK, 6'd0, 32'd0, 48'd0, 0);          // back to time zero
        // fill the heap, re-insert a queued id and a freed one, then drain by two ticks
        for (int i = 0; i < 64; i++)
            queue_req(REQ_INSERT, 6'(i), $urandom_range(3000), '0, 0);
        pend_q[$ - 20].hold = 1;   // receiver sits still while inserts back up
        queue_req(REQ_INSERT, 6'd17, 32'd1, '0, 0);          // already queued
        queue_req(REQ_DELETE, 6'd40, 32'd0, '0, 0);
        queue_req(REQ_INSERT, 6'd40, 32'd1, '0, 0);
        queue_req(REQ_TICK, 6'd0, 32'd0, 48'd1000, 0);
        queue_req(REQ_TICK, 6'd0, 32'd0, 48'd4000, 0);
        pend_q[$].drain = 1;
        sim_now = 48'd4000;
        for (int ph = 0; ph < 4; ph++) begin
            for (int k = 0; k < 95; k++) queue_random(ph);
            // pause the sender until everything is back before next profile
            queue_req(REQ_TICK, 6'd0, 32'd0, sim_now, ph);
            pend_q[$].drain = 1;
        end
    end

    // ------------------------------------------------------------------
    // Driver, receiver and monitor
    // ------------------------------------------------------------------
    bit running = 0;
    bit in_taken = 0;
    bit stim_done = 0;
    bit hold_go = 0;
    bit hold_seen = 0;
    int hold_cnt = 0;
    int cur_phase = 0;
    int send_idle;
    int recv_stall;

    always_comb begin
        case (cur_phase)
            1:       begin send_idle = 78; recv_stall = 0;  end
            2:       begin send_idle = 0;  recv_stall = 78; end
            3:       begin send_idle = 16; recv_stall = 16; end
            default: begin send_idle = 0;  recv_stall = 0;  end
        endcase
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        running <= 1'b1;
    end

    // Driver: new request only once the previous one went through.
    always @(negedge i_clk) begin
        if (running && (in_taken || !i_valid)) begin
            if (pend_q.size() == 0) begin
                i_valid <= 1'b0;
                stim_done <= 1'b1;
            end else if (pend_q[0].drain && due_results.size() != 0) begin
                i_valid <= 1'b0;
            end else if ($urandom_range(99) < send_idle) begin
                i_valid <= 1'b0;
            end else begin
                cur_req = pend_q.pop_front();
                i_req_type  <= cur_req.req;
                i_thread_id <= cur_req.id;
                i_timeout   <= cur_req.tmo;
                i_now_time  <= cur_req.now;
                cur_phase   <= cur_req.phase;
                if (cur_req.hold) hold_go <= 1'b1;
                i_valid <= 1'b1;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off of its own.
    always @(negedge i_clk) begin
        if (!running) begin
            i_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_ready <= 1'b0;
        end else if (hold_go && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_cnt <= 400;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Monitor: predict on request accept, check on result accept.
    always @(posedge i_clk) begin
        result_t exp_r;
        req_t    seen;
        in_taken <= i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            seen.req = t_req'(i_req_type);
            seen.id = i_thread_id;
            seen.tmo = i_timeout;
            seen.now = i_now_time;
            predict_request(seen);
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (due_results.size() == 0) begin
                $error("result with none pending: status %0d id %0d", o_status, o_out_id);
                errors++;
            end else begin
                exp_r = due_results.pop_front();
                if (o_status !== exp_r.st) begin
                    $error("status: expected %0d, got %0d", exp_r.st, o_status);
                    errors++;
                end
                if (o_out_id !== exp_r.id) begin
                    $error("out_id: expected %0d, got %0d", exp_r.id, o_out_id);
                    errors++;
                end
                if (o_is_last !== exp_r.last) begin
                    $error("is_last: expected %0d, got %0d", exp_r.last, o_is_last);
                    errors++;
                end
            end
        end
    end

    // End of run: all requests in, all results back, then a short tail.
    initial begin
        wait (stim_done);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (due_results.size() != 0) errors++;
        if (errors == 0) begin
            $display("PASS timeout_heap_queue");
        end else begin
            $display("FAIL timeout_heap_queue");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL timeout_heap_queue");
        $finish;
    end
endmodule

FILE: sim.f
rtl/core/thq_pkg.sv
rtl/core/thq_ctrl.sv
rtl/core/thq_datapath.sv
rtl/core/timeout_heap_queue.sv
tb/tb.sv
